/* hw/rtl/sttu_pkg.sv */
// ----------------------------------------------------------------------------
// Software timer table package
// Shared types and constants for the timer table unit: transaction payloads,
// operation and result codes, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package sttu_pkg;

  localparam int TIME_W  = 48;
  localparam int IVL_W   = 32;
  localparam int ID_W    = 16;
  localparam int WAIT_W  = 16;
  localparam int MAX_RES = 16;
  localparam int FIRE_W  = $clog2(MAX_RES + 1);

  localparam logic [WAIT_W-1:0] MAX_WAIT_RST   = 16'd100;
  localparam logic [WAIT_W-1:0] WAIT_FLOOR_RST = 16'd1;

  localparam logic CFG_MAX_WAIT   = 1'b0;
  localparam logic CFG_WAIT_FLOOR = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRE   = 2'd2,
    KIND_WAIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    op_t              opcode;
    logic [IVL_W-1:0] delay_ms;
    logic             repeat_req;
    logic [ID_W-1:0]  timer_id;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic              ok;
    logic [ID_W-1:0]   fired_id;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              due;
    logic              better;
    logic [WAIT_W-1:0] wait_cand;
  } arith_res_t;

endpackage

/* hw/rtl/sttu_arith.sv */
// ----------------------------------------------------------------------------
// Timer table slot arithmetic
// Shared add/compare unit: deadline sum, due test and clamped wait candidate
// for the slot currently under the scan.
// ----------------------------------------------------------------------------
module sttu_arith import sttu_pkg::*; (
  input  logic [TIME_W-1:0] now,
  input  logic [IVL_W-1:0]  interval,
  input  logic [TIME_W-1:0] deadline,
  input  logic [WAIT_W-1:0] wait_floor,
  input  logic [WAIT_W-1:0] best,
  output logic [TIME_W-1:0] sum,
  output arith_res_t        res
);

  logic [TIME_W:0]   diff;
  logic              due;
  logic [WAIT_W:0]   wsat;
  logic [WAIT_W:0]   wcl;

  assign sum  = now + {{(TIME_W-IVL_W){1'b0}}, interval};
  assign diff = {1'b0, deadline} - {1'b0, now};
  assign due  = diff[TIME_W] | (diff[TIME_W-1:0] == '0);

  always_comb begin
    if (due) begin
      wsat = '0;
    end else if (|diff[TIME_W-1:WAIT_W]) begin
      wsat = {1'b1, {WAIT_W{1'b0}}};
    end else begin
      wsat = {1'b0, diff[WAIT_W-1:0]};
    end
    wcl = (wsat < {1'b0, wait_floor}) ? {1'b0, wait_floor} : wsat;
    res.due       = due;
    res.better    = wcl < {1'b0, best};
    res.wait_cand = wcl[WAIT_W-1:0];
  end

endmodule

/* hw/rtl/software_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// Software timer table unit
// Slot table of one-shot and periodic timers against an internal millisecond
// clock; add, cancel, tick and query commands run as a scan over the slots.
//
//   channel | ports                        | transfer
//   --------+------------------------------+----------------------------------
//   input   | start, busy, in_data         | start high while busy low
//   result  | out_valid, out_data          | one-cycle strobe, no back-pressure
//   config  | cfg_we, cfg_idx, cfg_wdata   | write when cfg_we high
//
// A command holds busy high while it scans one slot per cycle through the
// shared add/compare unit behind a registered slot-memory read, then issues
// the final result from the flush state. Add and cancel end at the
// matching slot. Fired timers appear during the tick scan, at most one per
// cycle. Reset is synchronous and needs no clearing pass; results cannot stall.
// ----------------------------------------------------------------------------
module software_timer_table_unit import sttu_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [WAIT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(NUM_SLOTS);
  localparam logic [FIRE_W-1:0] FIRE_FULL = FIRE_W'(MAX_RES - 1);

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [ID_W-1:0]       next_id_r, next_id_nxt;
  logic [WAIT_W-1:0]     max_wait_r, wait_floor_r;
  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0]  periodic_r, periodic_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [WAIT_W-1:0]     best_r, best_nxt;
  logic [FIRE_W-1:0]     fire_cnt_r, fire_cnt_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  out_item_t             pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [IVL_W-1:0]      interval_mem [NUM_SLOTS];
  logic [TIME_W-1:0]     deadline_mem [NUM_SLOTS];
  logic [ID_W-1:0]       ident_mem    [NUM_SLOTS];
  logic [IVL_W-1:0]      interval_q;
  logic [TIME_W-1:0]     deadline_q;
  logic [ID_W-1:0]       ident_q;
  logic                  wr_all, wr_dl;

  logic [IVL_W-1:0]      ar_interval;
  logic [TIME_W-1:0]     ar_sum;
  arith_res_t            ar_res;

  logic                  slot_v, hit, scan_end, scan_stop;
  logic [WAIT_W-1:0]     best_fix;

  assign ar_interval = (item_r.opcode == OP_ADD) ? item_r.delay_ms : interval_q;

  sttu_arith u_arith (
    .now        (now_r),
    .interval   (ar_interval),
    .deadline   (deadline_q),
    .wait_floor (wait_floor_r),
    .best       (best_r),
    .sum        (ar_sum),
    .res        (ar_res)
  );

  assign slot_v   = valid_r[rd_idx_r];
  assign scan_end = (cnt_r == LAST_CNT) && !rd_vld_r;
  assign best_fix = (best_r == '0) ? WAIT_W'(1) : best_r;

  always_comb begin
    case (item_r.opcode)
      OP_ADD:    hit = rd_vld_r && !slot_v;
      OP_CANCEL: hit = rd_vld_r && slot_v && (ident_q == item_r.timer_id);
      OP_TICK:   hit = rd_vld_r && slot_v && ar_res.due;
      OP_QUERY:  hit = rd_vld_r && slot_v;
      default:   hit = 1'b0;
    endcase
    scan_stop = scan_end
             || (hit && ((item_r.opcode == OP_ADD) || (item_r.opcode == OP_CANCEL)))
             || (hit && (item_r.opcode == OP_TICK) && (fire_cnt_r == FIRE_FULL));
  end

  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = start ? ST_SCAN : ST_IDLE;
      ST_SCAN:  state_nxt = scan_stop ? ST_FLUSH : ST_SCAN;
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    now_nxt       = now_r;
    next_id_nxt   = next_id_r;
    valid_nxt     = valid_r;
    periodic_nxt  = periodic_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    best_nxt      = best_r;
    fire_cnt_nxt  = fire_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_all        = 1'b0;
    wr_dl         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt     = in_data;
          cnt_nxt      = '0;
          fire_cnt_nxt = '0;
          pend_vld_nxt = 1'b0;
          best_nxt     = max_wait_r;
          if (in_data.opcode == OP_TICK) begin
            now_nxt = now_r + TIME_W'(1);
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = (cnt_r != LAST_CNT) && !scan_stop;
        rd_idx_nxt = cnt_r[IDX_W-1:0];
        if (cnt_r != LAST_CNT) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        case (item_r.opcode)
          OP_ADD: begin
            if (hit) begin
              valid_nxt[rd_idx_r]    = 1'b1;
              periodic_nxt[rd_idx_r] = item_r.repeat_req;
              wr_all                 = 1'b1;
              next_id_nxt            = next_id_r + ID_W'(1);
              pend_nxt     = '{kind: KIND_ADD, ok: 1'b1, fired_id: next_id_r,
                               wait_ms: '0, last: 1'b1};
              pend_vld_nxt = 1'b1;
            end else if (scan_end) begin
              pend_nxt     = '{kind: KIND_ADD, ok: 1'b0, fired_id: '0,
                               wait_ms: '0, last: 1'b1};
              pend_vld_nxt = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (hit || scan_end) begin
              if (hit) begin
                valid_nxt[rd_idx_r] = 1'b0;
              end
              pend_nxt     = '{kind: KIND_CANCEL, ok: hit, fired_id: item_r.timer_id,
                               wait_ms: '0, last: 1'b1};
              pend_vld_nxt = 1'b1;
            end
          end
          OP_TICK: begin
            if (hit) begin
              fire_cnt_nxt = fire_cnt_r + FIRE_W'(1);
              if (periodic_r[rd_idx_r]) begin
                wr_dl = 1'b1;
              end else begin
                valid_nxt[rd_idx_r] = 1'b0;
              end
              if (pend_vld_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = pend_r;
              end
              pend_nxt     = '{kind: KIND_FIRE, ok: 1'b1, fired_id: ident_q,
                               wait_ms: '0, last: 1'b0};
              pend_vld_nxt = 1'b1;
            end
          end
          OP_QUERY: begin
            if (hit && ar_res.better) begin
              best_nxt = ar_res.wait_cand;
            end
            if (scan_end) begin
              pend_nxt     = '{kind: KIND_WAIT, ok: 1'b1, fired_id: '0,
                               wait_ms: best_fix, last: 1'b1};
              pend_vld_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
        end
        pend_vld_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_all) begin
      interval_mem[rd_idx_r] <= item_r.delay_ms;
      ident_mem[rd_idx_r]    <= next_id_r;
    end
    if (wr_all || wr_dl) begin
      deadline_mem[rd_idx_r] <= ar_sum;
    end
    interval_q <= interval_mem[cnt_r[IDX_W-1:0]];
    deadline_q <= deadline_mem[cnt_r[IDX_W-1:0]];
    ident_q    <= ident_mem[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_r        <= '0;
      next_id_r    <= '0;
      valid_r      <= '0;
      periodic_r   <= '0;
      rd_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      max_wait_r   <= MAX_WAIT_RST;
      wait_floor_r <= WAIT_FLOOR_RST;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      valid_r     <= valid_nxt;
      periodic_r  <= periodic_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_idx == CFG_MAX_WAIT) begin
          max_wait_r <= cfg_wdata;
        end else begin
          wait_floor_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    fire_cnt_r <= fire_cnt_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/sttu_checker.sv */
// ----------------------------------------------------------------------------
// Timer table port checker
// Port-level properties of the timer table unit, bound to the top level.
// ----------------------------------------------------------------------------
module sttu_checker import sttu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind != KIND_FIRE)) |-> out_data.last)
    else $error("add, cancel or wait answer without last");

  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == KIND_WAIT)) |-> (out_data.ok && (out_data.wait_ms != '0)))
    else $error("wait answer is zero or not ok");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !busy) |-> out_data.last)
    else $error("result while idle is not the final one");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !out_valid)
    else $error("result follows the final result of a transaction");

endmodule

bind software_timer_table_unit sttu_checker u_sttu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Timer table unit testbench
// Sends add, cancel, tick and query commands to the timer table unit under
// several wait-limit settings. A scoreboard class keeps its own copy of the
// slot table and the millisecond clock, works out the results each accepted
// command must produce, and checks every result strobe against them in order.
// ----------------------------------------------------------------------------
module tb import sttu_pkg::*;;

  localparam int SLOTS     = 16;
  localparam int SETTLE    = SLOTS + 4;
  localparam int QUIET_MAX = 2000;
  localparam int PHASE_LEN = 60;
  localparam int NUM_SETS  = 5;

  class timer_table_mirror;
    logic              live     [SLOTS];
    logic              periodic [SLOTS];
    logic [IVL_W-1:0]  period   [SLOTS];
    logic [TIME_W-1:0] deadline [SLOTS];
    logic [ID_W-1:0]   ident    [SLOTS];
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   next_ident;
    logic [WAIT_W-1:0] max_wait;
    logic [WAIT_W-1:0] wait_floor;
    out_item_t         pending_answers [$];
    int                commands;
    int                answers_checked;
    int                mismatches;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        live[i]     = 1'b0;
        periodic[i] = 1'b0;
        period[i]   = '0;
        deadline[i] = '0;
        ident[i]    = '0;
      end
      now_ms          = '0;
      next_ident      = '0;
      max_wait        = MAX_WAIT_RST;
      wait_floor      = WAIT_FLOOR_RST;
      commands        = 0;
      answers_checked = 0;
      mismatches      = 0;
    endfunction

    function void set_limit(logic idx, logic [WAIT_W-1:0] value);
      if (idx == CFG_MAX_WAIT) max_wait = value;
      else wait_floor = value;
    endfunction

    function int live_count();
      int i;
      int n;
      n = 0;
      for (i = 0; i < SLOTS; i++) if (live[i]) n++;
      return n;
    endfunction

    function logic [ID_W-1:0] pick_live_id();
      int i;
      int k;
      if (live_count() == 0) return ID_W'($urandom);
      k = $urandom_range(live_count() - 1);
      for (i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (k == 0) return ident[i];
          k--;
        end
      end
      return '0;
    endfunction

    function out_item_t answer(kind_t k, logic ok, logic [ID_W-1:0] id,
                               logic [WAIT_W-1:0] w, logic fin);
      out_item_t r;
      r.kind     = k;
      r.ok       = ok;
      r.fired_id = id;
      r.wait_ms  = w;
      r.last     = fin;
      return r;
    endfunction

    function string show(out_item_t r);
      return $sformatf("kind=%0d ok=%0d id=%0d wait=%0d last=%0d",
                       r.kind, r.ok, r.fired_id, r.wait_ms, r.last);
    endfunction

    function void apply_command(in_item_t c);
      int i;
      int fired;
      bit done;
      out_item_t held;
      logic [TIME_W-1:0] best;
      logic [TIME_W-1:0] w;
      commands++;
      done = 1'b0;
      case (c.opcode)
        OP_ADD: begin
          for (i = 0; i < SLOTS && !done; i++) begin
            if (!live[i]) begin
              live[i]     = 1'b1;
              periodic[i] = c.repeat_req;
              period[i]   = c.delay_ms;
              deadline[i] = now_ms + TIME_W'(c.delay_ms);
              ident[i]    = next_ident;
              next_ident  = next_ident + ID_W'(1);
              pending_answers.push_back(answer(KIND_ADD, 1'b1, ident[i], '0, 1'b1));
              done = 1'b1;
            end
          end
          if (!done) pending_answers.push_back(answer(KIND_ADD, 1'b0, '0, '0, 1'b1));
        end
        OP_CANCEL: begin
          for (i = 0; i < SLOTS && !done; i++) begin
            if (live[i] && ident[i] == c.timer_id) begin
              live[i] = 1'b0;
              done    = 1'b1;
            end
          end
          pending_answers.push_back(answer(KIND_CANCEL, done, c.timer_id, '0, 1'b1));
        end
        OP_TICK: begin
          now_ms = now_ms + TIME_W'(1);
          fired  = 0;
          for (i = 0; i < SLOTS && fired < MAX_RES; i++) begin
            if (live[i] && now_ms >= deadline[i]) begin
              if (fired > 0) pending_answers.push_back(held);
              held = answer(KIND_FIRE, 1'b1, ident[i], '0, 1'b0);
              fired++;
              if (periodic[i]) deadline[i] = now_ms + TIME_W'(period[i]);
              else live[i] = 1'b0;
            end
          end
          if (fired > 0) begin
            held.last = 1'b1;
            pending_answers.push_back(held);
          end
        end
        OP_QUERY: begin
          best = TIME_W'(max_wait);
          for (i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
              w = (deadline[i] > now_ms) ? deadline[i] - now_ms : '0;
              if (w < TIME_W'(wait_floor)) w = TIME_W'(wait_floor);
              if (w < best) best = w;
            end
          end
          if (best == '0) best = TIME_W'(1);
          pending_answers.push_back(answer(KIND_WAIT, 1'b1, '0, best[WAIT_W-1:0], 1'b1));
        end
        default: begin
        end
      endcase
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: expected no result, actual %s", $time, show(got));
        return;
      end
      want = pending_answers.pop_front();
      answers_checked++;
      if (got.kind !== want.kind || got.ok !== want.ok || got.fired_id !== want.fired_id ||
          got.wait_ms !== want.wait_ms || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: expected %s, actual %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  in_item_t          in_data   = '0;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic              cfg_idx   = CFG_MAX_WAIT;
  logic [WAIT_W-1:0] cfg_wdata = '0;

  timer_table_mirror mirror;
  bit                pacing;

  software_timer_table_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) mirror.match_result(out_data);
  end

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic issue(op_t op, logic [IVL_W-1:0] ivl, logic rep, logic [ID_W-1:0] id);
    in_item_t c;
    int r;
    int gap;
    c.opcode     = op;
    c.delay_ms   = ivl;
    c.repeat_req = rep;
    c.timer_id   = id;
    in_data <= c;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    mirror.apply_command(c);
    if (pacing) begin
      r = $urandom_range(99);
      if (r < 45) gap = 0;
      else if (r < 80) gap = $urandom_range(3, 1);
      else if (r < 96) gap = $urandom_range(12, 4);
      else gap = $urandom_range(40, 20);
      if (gap > 0) hold_off(gap);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (mirror.pending_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_wait_limits(logic [WAIT_W-1:0] max_ms, logic [WAIT_W-1:0] min_ms);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_WAIT;
    cfg_wdata <= max_ms;
    @(posedge clk);
    mirror.set_limit(CFG_MAX_WAIT, max_ms);
    cfg_idx   <= CFG_WAIT_FLOOR;
    cfg_wdata <= min_ms;
    @(posedge clk);
    mirror.set_limit(CFG_WAIT_FLOOR, min_ms);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [IVL_W-1:0] random_interval();
    int r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(8);
    if (r < 8) return $urandom_range(100);
    if (r < 9) return $urandom_range(200000);
    return $urandom;
  endfunction

  task automatic random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      issue(OP_ADD, random_interval(), 1'($urandom_range(1)), ID_W'($urandom));
    else if (pick < 50)
      issue(OP_CANCEL, $urandom, 1'($urandom_range(1)),
            ($urandom_range(4) == 0) ? ID_W'($urandom) : mirror.pick_live_id());
    else if (pick < 85)
      issue(OP_TICK, $urandom, 1'($urandom_range(1)), ID_W'($urandom));
    else
      issue(OP_QUERY, $urandom, 1'($urandom_range(1)), ID_W'($urandom));
  endtask

  task automatic fill_table();
    while (mirror.live_count() < SLOTS)
      issue(OP_ADD, random_interval(), 1'($urandom_range(1)), ID_W'($urandom));
    repeat (2) issue(OP_ADD, $urandom, 1'($urandom_range(1)), ID_W'($urandom));
    issue(OP_QUERY, $urandom, 1'($urandom_range(1)), ID_W'($urandom));
    repeat (12) issue(OP_TICK, $urandom, 1'($urandom_range(1)), ID_W'($urandom));
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (!rst_n || out_valid || (start && !busy)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [WAIT_W-1:0] max_set [NUM_SETS];
    logic [WAIT_W-1:0] min_set [NUM_SETS];
    int                p;
    int                first;
    mirror  = new();
    pacing  = 1'b0;
    max_set = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd1};
    min_set = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1};
    max_set[3] = WAIT_W'($urandom_range(300, 1));
    min_set[3] = WAIT_W'($urandom_range(40, 1));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_QUERY, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(OP_TICK, '0, 1'b0, '0);
    issue(OP_CANCEL, '0, 1'b0, 16'h0000);
    issue(OP_ADD, '0, 1'b0, 16'hFFFF);
    issue(OP_ADD, '0, 1'b1, '0);
    issue(OP_ADD, 32'hFFFF_FFFF, 1'b0, '0);
    issue(OP_ADD, 32'd3, 1'b1, '0);
    issue(OP_QUERY, '0, 1'b0, '0);
    repeat (4) issue(OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(OP_QUERY, '0, 1'b0, '0);
    issue(OP_CANCEL, '0, 1'b0, 16'hFFFF);
    issue(OP_CANCEL, '0, 1'b0, 16'd1);
    issue(OP_CANCEL, '0, 1'b0, 16'd1);
    issue(OP_TICK, '0, 1'b0, '0);
    issue(OP_QUERY, '0, 1'b0, '0);
    settle();

    for (p = 0; p < NUM_SETS; p++) begin
      set_wait_limits(max_set[p], min_set[p]);
      first = mirror.commands;
      pacing = 1'b1;
      fill_table();
      while (mirror.commands - first < PHASE_LEN) begin
        if (mirror.commands % 20 == 0) pacing = ($urandom_range(3) != 0);
        random_command();
      end
      pacing = 1'b0;
      settle();
    end

    $display("%0d commands sent, %0d results checked, %0d mismatches;",
             mirror.commands, mirror.answers_checked, mirror.mismatches);
    $display("wait limits set %0d ways, full table, zero and max intervals.",
             NUM_SETS + 1);
    if (mirror.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* software_timer_table_unit.f */
hw/rtl/sttu_pkg.sv
hw/rtl/sttu_arith.sv
hw/rtl/software_timer_table_unit.sv
hw/rtl/sttu_checker.sv
bench/tb.sv
